>>> rtl/cpra_pkg.sv
`timescale 1ns / 1ps

package cpra_pkg;

    localparam int NUM_PAGES     = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (NUM_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int PAGE_W        = $clog2(NUM_PAGES);
    localparam int CNT_W         = PAGE_W + 1;
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);
    localparam int WIDX_W        = $clog2(MAP_WORDS);
    localparam int POP_W         = BIT_W + 1;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_ALLOC   = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_FEW   = 3'd2,
        ST_NORUN = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_MARK_RD,
        S_MARK_WR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_FIND_FREE,
        OP_FIND_USED,
        OP_SET,
        OP_CLEAR
    } t_wu_op;

    typedef struct packed {
        logic              kind;
        logic [PAGE_W-1:0] first_page;
        logic [CNT_W-1:0]  run_pages;
        logic [CNT_W-1:0]  limit_pages;
        logic [PAGE_W-1:0] align_mask_pages;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [PAGE_W-1:0] start_page;
        logic [CNT_W-1:0]  free_pages;
    } t_out_item;

    typedef struct packed {
        t_wu_op                   op;
        logic [MAP_WORD_BITS-1:0] word;
        logic [BIT_W-1:0]         lo;
        logic [BIT_W-1:0]         hi;
        logic                     word_ok;
        logic [BIT_W-1:0]         bit_mask;
    } t_wu_req;

    typedef struct packed {
        logic                     found;
        logic [BIT_W-1:0]         pos;
        logic [MAP_WORD_BITS-1:0] new_word;
        logic [POP_W-1:0]         add_cnt;
    } t_wu_rsp;

endpackage

>>> rtl/cpra_map_ram.sv
`timescale 1ns / 1ps

module cpra_map_ram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [cpra_pkg::WIDX_W-1:0]        i_rd_addr,
    input  logic                              i_wr_en,
    input  logic [cpra_pkg::WIDX_W-1:0]        i_wr_addr,
    input  logic [cpra_pkg::MAP_WORD_BITS-1:0] i_wr_data,
    output logic [cpra_pkg::MAP_WORD_BITS-1:0] o_rd_data
);
    import cpra_pkg::*;

    logic [MAP_WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]     r_valid;
    logic [MAP_WORD_BITS-1:0] r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // a word never written reads as all used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> rtl/cpra_word_unit.sv
`timescale 1ns / 1ps

module cpra_word_unit (
    input  cpra_pkg::t_wu_req i_req,
    output cpra_pkg::t_wu_rsp o_rsp
);
    import cpra_pkg::*;

    logic [MAP_WORD_BITS-1:0] lo_m;
    logic [MAP_WORD_BITS-1:0] hi_m;
    logic [MAP_WORD_BITS-1:0] rng;
    logic [MAP_WORD_BITS-1:0] aligned;
    logic [MAP_WORD_BITS-1:0] cands;
    logic [MAP_WORD_BITS-1:0] newly;
    logic [MAP_WORD_BITS-1:0] new_word;
    logic [POP_W-1:0]         pop;
    logic [BIT_W-1:0]         pos;

    always_comb begin
        lo_m = {MAP_WORD_BITS{1'b1}} << i_req.lo;
        hi_m = {MAP_WORD_BITS{1'b1}} >> (BIT_W'(MAP_WORD_BITS - 1) - i_req.hi);
        rng  = lo_m & hi_m;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            aligned[b] = i_req.word_ok && ((BIT_W'(b) & i_req.bit_mask) == '0);
        end
    end

    always_comb begin
        new_word = i_req.word;
        cands    = '0;
        case (i_req.op)
            OP_FIND_FREE: cands = i_req.word & aligned & rng;
            OP_FIND_USED: cands = ~i_req.word & rng;
            OP_SET:       new_word = i_req.word | rng;
            OP_CLEAR:     new_word = i_req.word & ~rng;
            default:      cands = '0;
        endcase
    end

    // lowest set candidate bit
    always_comb begin
        pos = '0;
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (cands[b]) begin
                pos = BIT_W'(b);
            end
        end
    end

    // pages that turn free on a release
    always_comb begin
        newly = rng & ~i_req.word;
        pop   = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            pop = pop + POP_W'(newly[b]);
        end
    end

    always_comb begin
        o_rsp.found    = |cands;
        o_rsp.pos      = pos;
        o_rsp.new_word = new_word;
        o_rsp.add_cnt  = pop;
    end

endmodule

>>> rtl/contiguous_page_run_allocator.sv
`timescale 1ns / 1ps

// Bitmap page allocator, one item at a time. o_in_ready is high only while
// the sequencer is idle. Every map word touched goes through a registered
// read of the map RAM, then evaluate or write back, in the one shared word
// unit. A release reads each map word in the run and writes it back free.
// An allocation takes scan steps (advance one word, take a new start page,
// or drop a broken run), then marks each map word of the run used; a
// sparse map with many short holes needs the most steps. Zero-size,
// too-few-free and out-of-range items go straight to the done state. The
// map reads as all used after reset with no clearing pass. A finished
// result waits in the output register while the next item is taken.
module contiguous_page_run_allocator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cpra_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cpra_pkg::t_out_item  o_out_item
);
    import cpra_pkg::*;

    t_state              r_state, n_state;
    logic                r_kind, n_kind;
    logic [CNT_W-1:0]    r_run, n_run;
    logic [CNT_W-1:0]    r_lim, n_lim;
    logic [PAGE_W-1:0]   r_mask, n_mask;
    logic [CNT_W-1:0]    r_cur, n_cur;
    logic                r_in_run, n_in_run;
    logic [PAGE_W-1:0]   r_cand, n_cand;
    logic [CNT_W-1:0]    r_end, n_end;
    logic [PAGE_W-1:0]   r_lo, n_lo;
    logic [PAGE_W-1:0]   r_hi, n_hi;
    logic [WIDX_W-1:0]   r_wsel, n_wsel;
    t_status             r_status, n_status;
    logic [PAGE_W-1:0]   r_start, n_start;
    logic [CNT_W-1:0]    r_free_cnt, n_free_cnt;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic                     in_fire;
    logic [CNT_W:0]           rel_sum;
    logic [CNT_W:0]           rel_last;
    logic [WIDX_W-1:0]        cur_w;
    logic [WIDX_W:0]          w_inc;
    logic [CNT_W-1:0]         next_word;
    logic                     e_here;
    logic [WIDX_W-1:0]        rd_addr;
    logic                     wr_en;
    logic [MAP_WORD_BITS-1:0] rd_data;
    t_wu_req                  wu_req;
    t_wu_rsp                  wu_rsp;

    cpra_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wsel),
        .i_wr_data (wu_rsp.new_word),
        .o_rd_data (rd_data)
    );

    cpra_word_unit u_wu (
        .i_req (wu_req),
        .o_rsp (wu_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign rel_sum   = (CNT_W + 1)'(i_in_item.first_page) + (CNT_W + 1)'(i_in_item.run_pages);
    assign rel_last  = rel_sum - (CNT_W + 1)'(1);
    assign cur_w     = r_cur[PAGE_W-1:BIT_W];
    assign w_inc     = {1'b0, cur_w} + (WIDX_W + 1)'(1);
    assign next_word = {w_inc, BIT_W'(0)};
    assign e_here    = (r_end[CNT_W-1:BIT_W] == {1'b0, cur_w});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_in_run    <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_free_cnt  <= n_free_cnt;
            r_out_valid <= n_out_valid;
            r_in_run    <= n_in_run;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_run      <= n_run;
        r_lim      <= n_lim;
        r_mask     <= n_mask;
        r_cur      <= n_cur;
        r_cand     <= n_cand;
        r_end      <= n_end;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_wsel     <= n_wsel;
        r_start    <= n_start;
        r_out_item <= n_out_item;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_run       = r_run;
        n_lim       = r_lim;
        n_mask      = r_mask;
        n_cur       = r_cur;
        n_in_run    = r_in_run;
        n_cand      = r_cand;
        n_end       = r_end;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_wsel      = r_wsel;
        n_status    = r_status;
        n_start     = r_start;
        n_free_cnt  = r_free_cnt;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && !i_out_ready;

        rd_addr         = r_wsel;
        wr_en           = 1'b0;
        wu_req.op       = OP_FIND_FREE;
        wu_req.word     = rd_data;
        wu_req.lo       = r_cur[BIT_W-1:0];
        wu_req.hi       = BIT_W'(MAP_WORD_BITS - 1);
        wu_req.word_ok  = ((cur_w & r_mask[PAGE_W-1:BIT_W]) == '0);
        wu_req.bit_mask = r_mask[BIT_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind   = i_in_item.kind;
                    n_run    = i_in_item.run_pages;
                    n_mask   = i_in_item.align_mask_pages;
                    n_lim    = (i_in_item.limit_pages > CNT_W'(NUM_PAGES)) ?
                               CNT_W'(NUM_PAGES) : i_in_item.limit_pages;
                    n_cur    = '0;
                    n_in_run = 1'b0;
                    n_start  = '0;
                    n_lo     = i_in_item.first_page;
                    n_hi     = rel_last[PAGE_W-1:0];
                    n_wsel   = i_in_item.first_page[PAGE_W-1:BIT_W];
                    n_status = ST_OK;
                    if (i_in_item.run_pages == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_DONE;
                    end else if (i_in_item.kind == KIND_RELEASE) begin
                        if (rel_sum > (CNT_W + 1)'(NUM_PAGES)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_MARK_RD;
                        end
                    end else if (i_in_item.run_pages > r_free_cnt) begin
                        n_status = ST_FEW;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD: begin
                rd_addr = cur_w;
                n_end   = CNT_W'(r_cand) + r_run - CNT_W'(1);
                if (r_cur >= r_lim) begin
                    n_status = ST_NORUN;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN_EV;
                end
            end

            S_SCAN_EV: begin
                n_state = S_SCAN_RD;
                if (!r_in_run) begin
                    wu_req.op = OP_FIND_FREE;
                    if (wu_rsp.found) begin
                        n_cand   = {cur_w, wu_rsp.pos};
                        n_cur    = {1'b0, cur_w, wu_rsp.pos};
                        n_in_run = 1'b1;
                    end else begin
                        n_cur = next_word;
                    end
                end else begin
                    wu_req.op = OP_FIND_USED;
                    wu_req.hi = e_here ? r_end[BIT_W-1:0] : BIT_W'(MAP_WORD_BITS - 1);
                    if (r_end >= r_lim) begin
                        // any later start ends further out
                        n_status = ST_NORUN;
                        n_state  = S_DONE;
                    end else if (wu_rsp.found) begin
                        n_in_run = 1'b0;
                        n_cur    = CNT_W'({1'b0, cur_w, wu_rsp.pos}) + CNT_W'(1);
                    end else if (e_here) begin
                        n_start = r_cand;
                        n_lo    = r_cand;
                        n_hi    = r_end[PAGE_W-1:0];
                        n_wsel  = r_cand[PAGE_W-1:BIT_W];
                        n_state = S_MARK_RD;
                    end else begin
                        n_cur = next_word;
                    end
                end
            end

            S_MARK_RD: begin
                rd_addr = r_wsel;
                n_state = S_MARK_WR;
            end

            S_MARK_WR: begin
                wu_req.op = (r_kind == KIND_RELEASE) ? OP_SET : OP_CLEAR;
                wu_req.lo = (r_wsel == r_lo[PAGE_W-1:BIT_W]) ? r_lo[BIT_W-1:0] : '0;
                wu_req.hi = (r_wsel == r_hi[PAGE_W-1:BIT_W]) ? r_hi[BIT_W-1:0] :
                            BIT_W'(MAP_WORD_BITS - 1);
                wr_en = 1'b1;
                if (r_kind == KIND_RELEASE) begin
                    n_free_cnt = r_free_cnt + CNT_W'(wu_rsp.add_cnt);
                end
                if (r_wsel == r_hi[PAGE_W-1:BIT_W]) begin
                    if (r_kind == KIND_ALLOC) begin
                        n_free_cnt = r_free_cnt - r_run;
                    end
                    n_state = S_DONE;
                end else begin
                    n_wsel  = r_wsel + WIDX_W'(1);
                    n_state = S_MARK_RD;
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_item.status     = r_status;
                    n_out_item.start_page = r_start;
                    n_out_item.free_pages = r_free_cnt;
                    n_state               = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
